/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file csvt_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, muted while reset is held.
`define CSVT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold in the same cycle.
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CSVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	localparam logic [7:0] QUOTE_BYTE     = 8'h22;
	localparam logic [7:0] DELIMITER_RST  = 8'd44;

	// input action codes
	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_EOR  = 1'b1;

	typedef enum logic [2:0] {
		ST_NEW        = 3'd0,
		ST_PLAIN      = 3'd1,
		ST_QUOTED     = 3'd2,
		ST_QUOTE_SEEN = 3'd3
	} parse_state_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       value_valid;
		logic       field_end;
		logic       record_end;
		logic       quote_error;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/csvt_in_if.sv */
// ----------------------------------------------------------------------------
// csvt_in_if
// Byte channel into the tokenizer: valid/ready plus an action and one record byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvt_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/csvt_out_if.sv */
// ----------------------------------------------------------------------------
// csvt_out_if
// Token channel out of the tokenizer: valid/ready plus one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       value_valid;
	logic       field_end;
	logic       record_end;
	logic       quote_error;

	modport source (output valid, output value_byte, output value_valid,
		output field_end, output record_end, output quote_error, input ready);
	modport sink   (input valid, input value_byte, input value_valid,
		input field_end, input record_end, input quote_error, output ready);
endinterface

`default_nettype wire

/* rtl/csvt_parser.sv */
// ----------------------------------------------------------------------------
// csvt_parser
// Parse state register and the per-byte transition and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_parser import csvt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire in_item_t   item,
	input  wire logic [7:0] delimiter,
	output out_item_t       result
);

	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         is_delim;
	logic         is_quote;

	assign is_delim = (item.data_byte == delimiter);
	assign is_quote = (item.data_byte == QUOTE_BYTE);

	always_comb begin
		state_nxt          = state_q;
		result             = '0;
		if (item.action == ACT_EOR) begin
			result.record_end = 1'b1;
			if (state_q == ST_QUOTED) begin
				result.quote_error = 1'b1;
			end else begin
				result.field_end = 1'b1;
			end
			state_nxt = ST_NEW;
		end else begin
			unique case (state_q)
				ST_PLAIN: begin
					if (is_delim) begin
						result.field_end = 1'b1;
						state_nxt        = ST_NEW;
					end else begin
						result.value_byte  = item.data_byte;
						result.value_valid = 1'b1;
					end
				end
				ST_QUOTED: begin
					if (is_quote) begin
						state_nxt = ST_QUOTE_SEEN;
					end else begin
						result.value_byte  = item.data_byte;
						result.value_valid = 1'b1;
					end
				end
				ST_QUOTE_SEEN: begin
					priority if (is_delim) begin
						result.field_end = 1'b1;
						state_nxt        = ST_NEW;
					end else if (is_quote) begin
						// doubled quote: one literal quote, still quoted
						result.value_byte  = item.data_byte;
						result.value_valid = 1'b1;
						state_nxt          = ST_QUOTED;
					end else begin
						result.value_byte  = item.data_byte;
						result.value_valid = 1'b1;
						state_nxt          = ST_PLAIN;
					end
				end
				default: begin
					// new field; delimiter test wins over quote
					priority if (is_delim) begin
						result.field_end = 1'b1;
						state_nxt        = ST_NEW;
					end else if (is_quote) begin
						state_nxt = ST_QUOTED;
					end else begin
						result.value_byte  = item.data_byte;
						result.value_valid = 1'b1;
						state_nxt          = ST_PLAIN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NEW;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/csv_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a CSV record into field bytes and field/record end marks.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  bytes     in   valid/ready      action, data_byte
//  tokens    out  valid/ready      value_byte, value_valid, field_end,
//                                  record_end, quote_error
//  cfg       in   cfg_we           cfg_wdata -> delimiter
//
//  One transaction in and one out per cycle, sustained while tokens.ready stays high.
//  A byte passes the input register, the parse logic and the result register in turn.
//  Reset clears the parse state, both valid flags and sets delimiter to ','.
//  A stall on tokens holds the result register; an empty input register still
//  takes one more byte, and once both registers are full bytes.ready drops in
//  the same cycle as the stall.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer import csvt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	csvt_in_if.sink         bytes,
	csvt_out_if.source      tokens
);

	// delimiter register; write it only while the block is idle, the block itself does not enforce this
	logic [7:0] delimiter_q;

	// stage 1: captured input transaction
	in_item_t   item_s1;
	logic       valid_s1;

	// stage 2: result register
	out_item_t  result_s2;
	logic       valid_s2;

	out_item_t  result_nxt;
	logic       adv_s1;
	logic       take_in;

	// stage 1 moves into the result register when that is free or draining
	assign adv_s1       = valid_s1 && (!valid_s2 || tokens.ready);
	assign bytes.ready  = !valid_s1 || adv_s1;
	assign take_in      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RST;
		end else if (cfg_we) begin
			delimiter_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !adv_s1);
			valid_s2 <= adv_s1 || (valid_s2 && !tokens.ready);
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.action    <= bytes.action;
			item_s1.data_byte <= bytes.data_byte;
		end
		if (adv_s1) begin
			result_s2 <= result_nxt;
		end
	end

	// parse state steps once per transaction leaving stage 1
	csvt_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s1),
		.item      (item_s1),
		.delimiter (delimiter_q),
		.result    (result_nxt)
	);

	assign tokens.valid       = valid_s2;
	assign tokens.value_byte  = result_s2.value_byte;
	assign tokens.value_valid = result_s2.value_valid;
	assign tokens.field_end   = result_s2.field_end;
	assign tokens.record_end  = result_s2.record_end;
	assign tokens.quote_error = result_s2.quote_error;

endmodule

`default_nettype wire

/* rtl/csvt_checker.sv */
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokenizer's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module csvt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] value_byte,
	input wire logic       value_valid,
	input wire logic       field_end,
	input wire logic       record_end,
	input wire logic       quote_error
);

	// stalled result holds its value byte and its field and record end marks
	`CSVT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value_byte) && $stable(field_end) && $stable(record_end), "result changed under stall")

	// a value byte never comes with an end mark
	`CSVT_ASSERT_IMP(a_excl, clk, arst_n, out_valid && value_valid, !field_end && !record_end && !quote_error, "value byte with end mark")

	// quote error only on a record end, and then no field closes
	`CSVT_ASSERT_IMP(a_qerr, clk, arst_n, out_valid && quote_error, record_end && !field_end, "quote error outside record end")

	// record end closes a field or flags an error, exactly one
	`CSVT_ASSERT_IMP(a_rend, clk, arst_n, out_valid && record_end, (field_end != quote_error) && !value_valid, "bad record end")

	// a byte that is not part of the value reads as zero
	`CSVT_ASSERT_IMP(a_zero, clk, arst_n, out_valid && !value_valid, value_byte == 8'd0, "stray value byte")

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.value_byte  (tokens.value_byte),
	.value_valid (tokens.value_valid),
	.field_end   (tokens.field_end),
	.record_end  (tokens.record_end),
	.quote_error (tokens.quote_error)
);

`default_nettype wire

/* tb/csv_field_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// csv_field_tokenizer_test
// Self-checking bench for the CSV field tokenizer: directed records cover
// empty, quoted and broken fields and the delimiter extremes, then random
// records under several delimiter settings, with bursty input and a
// stalling token sink. A local parser predicts every token.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_test;
	import csvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int IDLE_LIMIT   = 2000;
	// the pipe holds an input and a result register; allow a little slack when draining
	localparam int DRAIN_CYCLES = 4;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	csvt_in_if  bytes_if ();
	csvt_out_if tokens_if ();

	csv_field_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bytes     (bytes_if),
		.tokens    (tokens_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Local parser: its own copy of the delimiter and of the field state.
	// ------------------------------------------------------------------------
	logic [7:0]   delim_now;
	parse_state_t field_state;
	out_item_t    expected_tokens[$];

	// bookkeeping
	int  mismatch_count;
	int  items_sent;
	int  records_sent;
	int  delim_settings;
	int  tokens_checked;
	int  field_ends_seen;
	int  quote_errors_seen;
	int  idle_cycles;
	int  burst_left;
	bit  bytes_held;

	// Advance the parser by one input transaction and return the token it owes.
	function automatic out_item_t tokenize_byte(in_item_t item);
		out_item_t    tok;
		parse_state_t nxt;
		tok = '0;
		nxt = field_state;
		if (item.action == ACT_EOR) begin
			tok.record_end = 1'b1;
			// an open quoted field swallows the last field and flags the error
			if (field_state == ST_QUOTED)
				tok.quote_error = 1'b1;
			else
				tok.field_end = 1'b1;
			nxt = ST_NEW;
		end else begin
			case (field_state)
				ST_PLAIN: begin
					if (item.data_byte == delim_now) begin
						tok.field_end = 1'b1;
						nxt = ST_NEW;
					end else begin
						tok.value_byte  = item.data_byte;
						tok.value_valid = 1'b1;
					end
				end
				ST_QUOTED: begin
					// inside quotes the quote test comes first, delimiter is literal
					if (item.data_byte == QUOTE_BYTE) begin
						nxt = ST_QUOTE_SEEN;
					end else begin
						tok.value_byte  = item.data_byte;
						tok.value_valid = 1'b1;
					end
				end
				ST_QUOTE_SEEN: begin
					if (item.data_byte == delim_now) begin
						tok.field_end = 1'b1;
						nxt = ST_NEW;
					end else if (item.data_byte == QUOTE_BYTE) begin
						// doubled quote: one literal quote, still quoted
						tok.value_byte  = item.data_byte;
						tok.value_valid = 1'b1;
						nxt = ST_QUOTED;
					end else begin
						// stray byte after closing quote: field carries on unquoted
						tok.value_byte  = item.data_byte;
						tok.value_valid = 1'b1;
						nxt = ST_PLAIN;
					end
				end
				default: begin
					if (item.data_byte == delim_now) begin
						tok.field_end = 1'b1;
						nxt = ST_NEW;
					end else if (item.data_byte == QUOTE_BYTE) begin
						nxt = ST_QUOTED;
					end else begin
						tok.value_byte  = item.data_byte;
						tok.value_valid = 1'b1;
						nxt = ST_PLAIN;
					end
				end
			endcase
		end
		field_state = nxt;
		return tok;
	endfunction

	// Byte picker biased towards the interesting values: quote and delimiter.
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0:       b = QUOTE_BYTE;
			1:       b = delim_now;
			2, 3, 4, 5: b = 8'($urandom_range(0, 255));
			default: b = 8'($urandom_range(32, 126));
		endcase
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// Byte source: one transaction per call, in bursts with random gaps.
	// valid is only lowered when a gap starts or sending stops, never toggled within a step.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic act, input logic [7:0] b);
		in_item_t  item;
		out_item_t tok;
		item.action    = act;
		item.data_byte = b;
		bytes_if.valid     <= 1'b1;
		bytes_if.action    <= act;
		bytes_if.data_byte <= b;
		bytes_held = 1'b1;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		// accepted at this edge
		tok = tokenize_byte(item);
		expected_tokens = {expected_tokens, tok};
		items_sent++;
		if (act == ACT_EOR)
			records_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			bytes_if.valid <= 1'b0;
			bytes_held = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
	endtask

	// Stop sending, let every token come back and the pipe settle.
	task automatic wait_idle();
		if (bytes_held) begin
			bytes_if.valid <= 1'b0;
			bytes_held = 1'b0;
		end
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; only called once the block is idle.
	task automatic set_delimiter(input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		delim_now = v;
		delim_settings++;
	endtask

	// One random record: mostly well formed, with the odd unterminated quote
	// and stray byte after a closing quote thrown in.
	task automatic send_record();
		int         n_fields;
		int         len;
		bit         quoted;
		bit         unterminated;
		logic [7:0] b;
		n_fields = $urandom_range(1, 6);
		for (int f = 0; f < n_fields; f++) begin
			// an opening quote is impossible when the delimiter is the quote
			quoted = (delim_now != QUOTE_BYTE) && ($urandom_range(0, 9) < 4);
			len    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
			unterminated = 1'b0;
			if (quoted) begin
				send_byte(ACT_DATA, QUOTE_BYTE);
				for (int i = 0; i < len; i++) begin
					b = pick_byte();
					send_byte(ACT_DATA, b);
					if (b == QUOTE_BYTE)
						send_byte(ACT_DATA, QUOTE_BYTE);
				end
				unterminated = (f == n_fields - 1) && ($urandom_range(0, 9) == 0);
				if (!unterminated) begin
					send_byte(ACT_DATA, QUOTE_BYTE);
					if ($urandom_range(0, 7) == 0) begin
						do
							b = pick_byte();
						while (b == QUOTE_BYTE || b == delim_now);
						send_byte(ACT_DATA, b);
					end
				end
			end else begin
				for (int i = 0; i < len; i++) begin
					do
						b = pick_byte();
					while (b == delim_now || (i == 0 && b == QUOTE_BYTE));
					send_byte(ACT_DATA, b);
				end
			end
			if (f < n_fields - 1)
				send_byte(ACT_DATA, delim_now);
		end
		send_byte(ACT_EOR, 8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------------
	// Token sink: stall pattern switches mode whenever its random run length runs out.
	// Each accepted transaction is checked against the oldest prediction.
	// The watchdog lives here too, counting cycles with no transaction.
	// ------------------------------------------------------------------------
	int unsigned stall_mode;
	int unsigned stall_left;
	int unsigned stall_phase;

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n) begin
			if (tokens_if.valid && tokens_if.ready) begin
				got.value_byte  = tokens_if.value_byte;
				got.value_valid = tokens_if.value_valid;
				got.field_end   = tokens_if.field_end;
				got.record_end  = tokens_if.record_end;
				got.quote_error = tokens_if.quote_error;
				if (expected_tokens.size() == 0) begin
					$error("token transaction with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					tokens_checked++;
					if (want.field_end)
						field_ends_seen++;
					if (want.quote_error)
						quote_errors_seen++;
					if (got.value_byte !== want.value_byte) begin
						$error("value_byte: expected %0h, got %0h",
							want.value_byte, got.value_byte);
						mismatch_count++;
					end
					if (got.value_valid !== want.value_valid) begin
						$error("value_valid: expected %0b, got %0b",
							want.value_valid, got.value_valid);
						mismatch_count++;
					end
					if (got.field_end !== want.field_end) begin
						$error("field_end: expected %0b, got %0b",
							want.field_end, got.field_end);
						mismatch_count++;
					end
					if (got.record_end !== want.record_end) begin
						$error("record_end: expected %0b, got %0b",
							want.record_end, got.record_end);
						mismatch_count++;
					end
					if (got.quote_error !== want.quote_error) begin
						$error("quote_error: expected %0b, got %0b",
							want.quote_error, got.quote_error);
						mismatch_count++;
					end
				end
			end

			if ((bytes_if.valid && bytes_if.ready) || (tokens_if.valid && tokens_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end

			// pick the next stall pattern
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(64, 256);
			end else begin
				stall_left--;
			end
			stall_phase++;
			case (stall_mode)
				0:       tokens_if.ready <= 1'b1;                        // free flowing
				1:       tokens_if.ready <= ($urandom_range(0, 1) == 1); // coin toss
				2:       tokens_if.ready <= (stall_phase % 3 == 0);      // one in three
				default: tokens_if.ready <= ($urandom_range(0, 9) < 8);  // light stalls
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Default comma: empty fields, quoting, doubled quotes, stray bytes after
	// a closing quote, literal quote in a plain field, record ends in every state.
	task automatic test_basic_fields();
		send_byte(ACT_DATA, 8'h00);       // lowest byte opens a plain field
		send_byte(ACT_DATA, 8'd44);       // ends it
		send_byte(ACT_DATA, 8'd44);       // empty field
		send_byte(ACT_DATA, QUOTE_BYTE);  // opens quoted field
		send_byte(ACT_DATA, 8'd44);       // delimiter is literal inside quotes
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_DATA, QUOTE_BYTE);  // doubled quote -> one literal quote
		send_byte(ACT_DATA, 8'hFF);       // highest byte
		send_byte(ACT_DATA, QUOTE_BYTE);  // closing quote
		send_byte(ACT_DATA, 8'd44);
		send_byte(ACT_DATA, "b");
		send_byte(ACT_DATA, QUOTE_BYTE);  // quote inside plain field is literal
		send_byte(ACT_EOR, 8'h00);        // closes plain field
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_DATA, "c");
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_DATA, "d");         // after closing quote: carries on unquoted
		send_byte(ACT_EOR, 8'hFF);
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_EOR, 8'h5A);        // record ends in open quotes -> error
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_DATA, QUOTE_BYTE);
		send_byte(ACT_EOR, 8'hA5);        // ends just after a closing quote, no error
		send_byte(ACT_EOR, 8'h00);        // empty record
		wait_idle();
	endtask

	// Delimiter equal to the quote, and the all-zeros / all-ones extremes.
	task automatic test_delimiter_extremes();
		// leave a quoted field open, then make the quote the delimiter
		send_byte(ACT_DATA, QUOTE_BYTE);
		wait_idle();
		set_delimiter(QUOTE_BYTE);
		send_byte(ACT_DATA, "x");
		send_byte(ACT_DATA, QUOTE_BYTE);  // still a quote in open quotes
		send_byte(ACT_DATA, QUOTE_BYTE);  // after it, the delimiter test wins
		send_byte(ACT_DATA, QUOTE_BYTE);  // new field: delimiter, empty field
		send_byte(ACT_DATA, "y");
		send_byte(ACT_DATA, QUOTE_BYTE);  // ends a plain field
		send_byte(ACT_EOR, 8'h00);
		wait_idle();
		set_delimiter(8'h00);
		send_byte(ACT_DATA, 8'h00);
		send_byte(ACT_DATA, 8'h2C);       // comma is plain data now
		send_byte(ACT_DATA, 8'h00);
		send_byte(ACT_EOR, 8'h00);
		wait_idle();
		set_delimiter(8'hFF);
		send_byte(ACT_DATA, 8'hFE);
		send_byte(ACT_DATA, 8'hFF);
		send_byte(ACT_EOR, 8'hFF);
		wait_idle();
	endtask

	// Random records, each phase under its own delimiter, with some noise.
	task automatic test_random_records();
		logic [7:0] phase_delims[8];
		int         target;
		int         len;
		phase_delims = '{8'd44, 8'd9, 8'd0, 8'd255, QUOTE_BYTE, 8'd59, 8'd0, 8'd44};
		phase_delims[6] = 8'($urandom_range(0, 255));
		foreach (phase_delims[p]) begin
			set_delimiter(phase_delims[p]);
			target = items_sent + 125;
			while (items_sent < target) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise: raw biased bytes, sometimes a record end, sometimes none
					len = $urandom_range(1, 20);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 19) == 0)
							send_byte(ACT_EOR, 8'($urandom_range(0, 255)));
						else
							send_byte(ACT_DATA, pick_byte());
					end
					if ($urandom_range(0, 1) == 0)
						send_byte(ACT_EOR, 8'($urandom_range(0, 255)));
				end else begin
					send_record();
				end
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 8'h00;
		bytes_if.valid     = 1'b0;
		bytes_if.action    = ACT_DATA;
		bytes_if.data_byte = 8'h00;
		tokens_if.ready    = 1'b0;
		delim_now          = DELIMITER_RST;
		field_state        = ST_NEW;
		mismatch_count     = 0;
		items_sent         = 0;
		records_sent       = 0;
		delim_settings     = 1;
		tokens_checked     = 0;
		field_ends_seen    = 0;
		quote_errors_seen  = 0;
		idle_cycles        = 0;
		burst_left         = $urandom_range(1, 12);
		bytes_held         = 1'b0;
		stall_mode         = 0;
		stall_left         = 0;
		stall_phase        = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_basic_fields();
		test_delimiter_extremes();
		test_random_records();

		wait_idle();
		$display("Sent %0d bytes in %0d records under %0d delimiter settings.",
			items_sent, records_sent, delim_settings);
		$display("Checked %0d tokens, %0d field ends and %0d unclosed quotes among them.",
			tokens_checked, field_ends_seen, quote_errors_seen);
		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
